// ===== rtl/core/hbrp_pkg.sv =====
// shared types and constants of the http byte range parser
package hbrp_pkg;

   localparam int OUT_W = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic KIND_RANGE   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic             item_kind;
      logic [OUT_W-1:0] range_first;
      logic [OUT_W-1:0] range_limit;
      logic             header_ok;
      logic             any_servable;
      logic             run_end;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

endpackage

// ===== rtl/core/http_byte_range_parser_top.sv =====
// top level of the http byte range parser with csr port and result queue
// Takes one Range header character per transfer, at one transfer per cycle, and
// returns each parsed range as a half-open interval clamped to file_length, then a
// verdict on the transfer marked final. Results enter the result queue at the clock edge of the
// transfer that causes them. A character that closes a range on the final transfer gives two
// results, which leave one at a time; a four-entry result queue absorbs them, and req_ready
// stays high while at least two entries are free, so with the output side always ready the
// input runs at one transfer per cycle. file_length sits at csr byte address 0 and should
// only be written between headers.
module http_byte_range_parser_top #(
   parameter int OFFSET_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_header_byte,
   input  logic        req_is_final,
   input  logic        req_no_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_item_kind,
   output logic [63:0] rsp_range_first,
   output logic [63:0] rsp_range_limit,
   output logic        rsp_header_ok,
   output logic        rsp_any_servable,
   output logic        rsp_run_end,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import hbrp_pkg::*;

   localparam logic CSR_IDX_FILE_LENGTH = 1'b0;

   logic [63:0]  file_length_ff, file_length_in;
   logic         csr_write;
   logic         in_fire;
   rsp_push_type push;
   rsp_item_type head_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[3] == CSR_IDX_FILE_LENGTH);
   assign file_length_in = csr_write ? csr_pwdata : file_length_ff;
   assign csr_prdata = (csr_paddr[3] == CSR_IDX_FILE_LENGTH) ? file_length_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
      end else begin
         file_length_ff <= file_length_in;
      end
   end

   assign in_fire = req_valid && req_ready;

   hbrp_parse #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .in_byte     (req_header_byte),
      .in_final    (req_is_final),
      .in_none     (req_no_byte),
      .file_length (file_length_ff[OFFSET_BITS-1:0]),
      .push        (push)
   );

   hbrp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head_item)
   );

   assign rsp_item_kind    = head_item.item_kind;
   assign rsp_range_first  = head_item.range_first;
   assign rsp_range_limit  = head_item.range_limit;
   assign rsp_header_ok    = head_item.header_ok;
   assign rsp_any_servable = head_item.any_servable;
   assign rsp_run_end      = head_item.run_end;

endmodule

// ===== rtl/core/hbrp_parse.sv =====
// per-byte range header parser state and interval computation
module hbrp_parse #(
   parameter int OFFSET_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_fire,
   input  logic [7:0]             in_byte,
   input  logic                   in_final,
   input  logic                   in_none,
   input  logic [OFFSET_BITS-1:0] file_length,
   output hbrp_pkg::rsp_push_type push
);
   import hbrp_pkg::*;

   localparam logic [3:0] PH_PREFIX    = 4'd0;
   localparam logic [3:0] PH_LEAD      = 4'd1;
   localparam logic [3:0] PH_SUF_FIRST = 4'd2;
   localparam logic [3:0] PH_SUF_DIG   = 4'd3;
   localparam logic [3:0] PH_START     = 4'd4;
   localparam logic [3:0] PH_DASH      = 4'd5;
   localparam logic [3:0] PH_END       = 4'd6;
   localparam logic [3:0] PH_AFTER     = 4'd7;
   localparam logic [3:0] PH_ERR       = 4'd8;
   localparam logic [3:0] PH_BADPFX    = 4'd9;

   localparam logic [1:0] FIN_NONE   = 2'd0;
   localparam logic [1:0] FIN_SUFFIX = 2'd1;
   localparam logic [1:0] FIN_CLOSED = 2'd2;
   localparam logic [1:0] FIN_OPEN   = 2'd3;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;
   localparam logic [7:0] CASE_GAP = 8'h20;
   localparam logic [2:0] PREFIX_LEN = 3'd6;

   localparam logic [OFFSET_BITS-1:0] OMASK = '1;
   localparam logic [OFFSET_BITS-1:0] Q_LIM = OMASK / 10;
   localparam logic [3:0] R_LIM = 4'(OMASK % 10);

   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0: ch = 8'h62;
         3'd1: ch = 8'h79;
         3'd2: ch = 8'h74;
         3'd3: ch = 8'h65;
         3'd4: ch = 8'h73;
         default: ch = 8'h3d;
      endcase
      return ch;
   endfunction

   function automatic logic fin_valid(input logic [1:0] kind,
                                      input logic [OFFSET_BITS-1:0] fv,
                                      input logic [OFFSET_BITS-1:0] sv);
      logic pass;
      unique case (kind)
         FIN_SUFFIX: pass = (fv != '0);
         FIN_CLOSED: pass = (sv >= fv);
         default:    pass = 1'b1;
      endcase
      return pass;
   endfunction

   logic [3:0]             phase_ff, phase_in;
   logic [2:0]             prefix_pos_ff, prefix_pos_in;
   logic [OFFSET_BITS-1:0] first_value_ff, first_value_in;
   logic [OFFSET_BITS-1:0] second_value_ff, second_value_in;
   logic                   seen_servable_ff, seen_servable_in;
   logic                   syntax_ok_ff, syntax_ok_in;

   logic [7:0]             lower_byte;
   logic                   is_digit, is_blank;
   logic [OFFSET_BITS-1:0] digit_val;
   logic [OFFSET_BITS-1:0] acc_src, acc_next;
   logic                   acc_ovf;

   logic [1:0]             fin_byte, fin_end, fin_sel;
   logic [OFFSET_BITS-1:0] emit_first, emit_limit;
   logic                   emit, emit_hit;
   logic                   verdict_ok, verdict_serv;
   rsp_item_type           range_item, verdict_item;

   assign lower_byte = (in_byte >= CH_UP_A && in_byte <= CH_UP_Z) ? in_byte + CASE_GAP : in_byte;
   assign is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
   assign is_blank   = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
   assign digit_val  = OFFSET_BITS'(in_byte[3:0]);

   // decimal accumulate of whichever number is being read
   assign acc_src  = (phase_ff == PH_END) ? second_value_ff : first_value_ff;
   assign acc_ovf  = acc_src > ((in_byte[3:0] <= R_LIM) ? Q_LIM : Q_LIM - 1'b1);
   assign acc_next = (acc_src << 3) + (acc_src << 1) + digit_val;

   always_comb begin
      phase_in         = phase_ff;
      prefix_pos_in    = prefix_pos_ff;
      first_value_in   = first_value_ff;
      second_value_in  = second_value_ff;
      seen_servable_in = seen_servable_ff;
      syntax_ok_in     = syntax_ok_ff;
      fin_byte         = FIN_NONE;
      fin_end          = FIN_NONE;

      if (in_fire && !in_none) begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if (prefix_pos_ff < PREFIX_LEN && lower_byte == prefix_char(prefix_pos_ff)) begin
                  prefix_pos_in = prefix_pos_ff + 3'd1;
                  if (prefix_pos_in == PREFIX_LEN) begin
                     phase_in = PH_LEAD;
                  end
               end else begin
                  phase_in     = PH_BADPFX;
                  syntax_ok_in = 1'b0;
               end
            end
            PH_LEAD: begin
               if (is_blank) begin
                  phase_in = PH_LEAD;
               end else if (in_byte == CH_DASH) begin
                  phase_in = PH_SUF_FIRST;
               end else if (is_digit) begin
                  first_value_in = digit_val;
                  phase_in       = PH_START;
               end else begin
                  phase_in     = PH_ERR;
                  syntax_ok_in = 1'b0;
               end
            end
            PH_SUF_FIRST: begin
               if (is_digit) begin
                  first_value_in = digit_val;
                  phase_in       = PH_SUF_DIG;
               end else begin
                  phase_in     = PH_ERR;
                  syntax_ok_in = 1'b0;
               end
            end
            PH_SUF_DIG: begin
               if (!is_digit) begin
                  fin_byte = FIN_SUFFIX;
               end else if (acc_ovf) begin
                  phase_in     = PH_ERR;
                  syntax_ok_in = 1'b0;
               end else begin
                  first_value_in = acc_next;
               end
            end
            PH_START: begin
               if (is_digit) begin
                  if (acc_ovf) begin
                     phase_in     = PH_ERR;
                     syntax_ok_in = 1'b0;
                  end else begin
                     first_value_in = acc_next;
                  end
               end else if (in_byte == CH_DASH) begin
                  phase_in = PH_DASH;
               end else begin
                  phase_in     = PH_ERR;
                  syntax_ok_in = 1'b0;
               end
            end
            PH_DASH: begin
               if (in_byte == CH_COMMA || is_blank) begin
                  fin_byte = FIN_OPEN;
               end else if (is_digit) begin
                  second_value_in = digit_val;
                  phase_in        = PH_END;
               end else begin
                  phase_in     = PH_ERR;
                  syntax_ok_in = 1'b0;
               end
            end
            PH_END: begin
               if (!is_digit) begin
                  fin_byte = FIN_CLOSED;
               end else if (acc_ovf) begin
                  phase_in     = PH_ERR;
                  syntax_ok_in = 1'b0;
               end else begin
                  second_value_in = acc_next;
               end
            end
            PH_AFTER: begin
               if (in_byte == CH_COMMA) begin
                  phase_in = PH_LEAD;
               end else if (!is_blank) begin
                  phase_in     = PH_ERR;
                  syntax_ok_in = 1'b0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // a spec closed by this byte, then the byte itself as a separator
      if (fin_byte != FIN_NONE) begin
         if (fin_valid(fin_byte, first_value_in, second_value_in)) begin
            phase_in = PH_AFTER;
            if (in_byte == CH_COMMA) begin
               phase_in = PH_LEAD;
            end else if (!is_blank) begin
               phase_in     = PH_ERR;
               syntax_ok_in = 1'b0;
            end
         end else begin
            fin_byte     = FIN_NONE;
            phase_in     = PH_ERR;
            syntax_ok_in = 1'b0;
         end
      end

      // end of header closes whatever spec is open
      if (in_fire && in_final) begin
         unique case (phase_in)
            PH_PREFIX: begin
               phase_in     = PH_BADPFX;
               syntax_ok_in = 1'b0;
            end
            PH_LEAD, PH_SUF_FIRST, PH_START: begin
               phase_in     = PH_ERR;
               syntax_ok_in = 1'b0;
            end
            PH_SUF_DIG: fin_end = FIN_SUFFIX;
            PH_DASH:    fin_end = FIN_OPEN;
            PH_END:     fin_end = FIN_CLOSED;
            default:    fin_end = FIN_NONE;
         endcase
         if (fin_end != FIN_NONE && !fin_valid(fin_end, first_value_in, second_value_in)) begin
            fin_end      = FIN_NONE;
            phase_in     = PH_ERR;
            syntax_ok_in = 1'b0;
         end
      end

      fin_sel = (fin_byte != FIN_NONE) ? fin_byte : fin_end;

      unique case (fin_sel)
         FIN_SUFFIX: begin
            emit_first = (first_value_in >= file_length) ? '0 : file_length - first_value_in;
            emit_limit = file_length;
         end
         FIN_CLOSED: begin
            emit_first = first_value_in;
            emit_limit = (file_length == '0 || second_value_in >= file_length - 1'b1) ?
                         file_length : second_value_in + 1'b1;
         end
         FIN_OPEN: begin
            emit_first = first_value_in;
            emit_limit = file_length;
         end
         default: begin
            emit_first = '0;
            emit_limit = '0;
         end
      endcase

      emit     = (fin_sel != FIN_NONE);
      emit_hit = (emit_first < file_length);
      if (!emit_hit) begin
         emit_first = file_length;
         emit_limit = file_length;
      end
      if (emit && emit_hit) begin
         seen_servable_in = 1'b1;
      end

      verdict_ok   = (phase_in == PH_BADPFX) ? 1'b0 : syntax_ok_in;
      verdict_serv = (phase_in == PH_BADPFX) ? 1'b1 : seen_servable_in;

      if (in_fire && in_final) begin
         phase_in         = PH_PREFIX;
         prefix_pos_in    = 3'd0;
         first_value_in   = '0;
         second_value_in  = '0;
         seen_servable_in = 1'b0;
         syntax_ok_in     = 1'b1;
      end
   end

   always_comb begin
      range_item.item_kind    = KIND_RANGE;
      range_item.range_first  = OUT_W'(emit_first);
      range_item.range_limit  = OUT_W'(emit_limit);
      range_item.header_ok    = 1'b0;
      range_item.any_servable = 1'b0;
      range_item.run_end      = 1'b0;

      verdict_item.item_kind    = KIND_VERDICT;
      verdict_item.range_first  = '0;
      verdict_item.range_limit  = '0;
      verdict_item.header_ok    = verdict_ok;
      verdict_item.any_servable = verdict_serv;
      verdict_item.run_end      = 1'b1;

      push.count = 2'(emit) + 2'(in_fire && in_final);
      push.item0 = emit ? range_item : verdict_item;
      push.item1 = verdict_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_PREFIX;
         prefix_pos_ff    <= 3'd0;
         first_value_ff   <= '0;
         second_value_ff  <= '0;
         seen_servable_ff <= 1'b0;
         syntax_ok_ff     <= 1'b1;
      end else begin
         phase_ff         <= phase_in;
         prefix_pos_ff    <= prefix_pos_in;
         first_value_ff   <= first_value_in;
         second_value_ff  <= second_value_in;
         seen_servable_ff <= seen_servable_in;
         syntax_ok_ff     <= syntax_ok_in;
      end
   end

   // the verdict is always the last result of a header
   a_final_verdict: assert property (@(posedge clock) disable iff (reset)
      in_fire && in_final |-> push.count != 2'd0 &&
         (push.count == 2'd2 || push.item0.item_kind == KIND_VERDICT))
      else $error("final transfer without trailing verdict");

   a_mid_range_only: assert property (@(posedge clock) disable iff (reset)
      in_fire && !in_final |-> push.count == 2'd0 ||
         (push.count == 2'd1 && push.item0.item_kind == KIND_RANGE))
      else $error("non-final transfer produced a verdict or two results");

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      in_fire && in_final |=> phase_ff == PH_PREFIX && syntax_ok_ff && !seen_servable_ff)
      else $error("parser state not cleared after verdict");

endmodule

// ===== rtl/core/hbrp_rsp_queue.sv =====
// result queue taking up to two result items per cycle
module hbrp_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  hbrp_pkg::rsp_push_type push,
   output logic                   has_room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hbrp_pkg::rsp_item_type out_item
);
   import hbrp_pkg::*;

   rsp_item_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[head_ff];
   assign pop       = out_valid && out_ready;
   // room for two results so a final transfer that closes a range always fits
   assign has_room  = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

   assign head_in  = head_ff + QUEUE_PTR_W'(pop);
   assign tail_in  = tail_ff + QUEUE_PTR_W'(push.count);
   assign count_in = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[tail_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[tail_ff + QUEUE_PTR_W'(1)] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |->
         32'(count_ff) + 32'(push.count) <= 32'(QUEUE_DEPTH) + 32'(pop))
      else $error("result queue overflow");

endmodule

// ===== verif/tb.sv =====
// testbench for the http byte range parser: header streams, clamping, errors and csr writes
`timescale 1ns / 100ps

module tb;
   import hbrp_pkg::*;

   localparam int          CYCLE_LIMIT     = 600000;
   localparam logic [3:0]  REG_FILE_LENGTH = 4'd0;
   localparam logic [63:0] ALL_ONES        = '1;
   localparam logic [47:0] PREFIX_TEXT     = "bytes=";
   localparam logic [7:0]  CH_TAB    = 8'h09;
   localparam logic [7:0]  CH_SPACE  = 8'h20;
   localparam logic [7:0]  CH_COMMA  = 8'h2C;
   localparam logic [7:0]  CH_DASH   = 8'h2D;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_NINE   = 8'h39;
   localparam logic [7:0]  CH_EQUALS = 8'h3D;
   localparam logic [7:0]  CH_UPPER_A = 8'h41;
   localparam logic [7:0]  CH_UPPER_Z = 8'h5A;
   localparam logic [7:0]  CASE_GAP  = 8'h20;

   typedef enum logic [3:0] {
      ST_PREFIX, ST_LEAD, ST_SUFFIX_FIRST, ST_SUFFIX_DIGITS, ST_FIRST_NUM,
      ST_DASH, ST_LAST_NUM, ST_SPEC_DONE, ST_ERROR, ST_BAD_PREFIX
   } parse_state_type;

   typedef enum int {
      SPEC_CLOSED, SPEC_OPEN, SPEC_SUFFIX, SPEC_BACKWARD, SPEC_ZERO_SUFFIX,
      SPEC_BARE_DASH, SPEC_OVERFLOW, SPEC_STRAY
   } spec_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_header_byte = 8'h00;
   logic        req_is_final = 1'b0;
   logic        req_no_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_item_kind;
   logic [63:0] rsp_range_first;
   logic [63:0] rsp_range_limit;
   logic        rsp_header_ok;
   logic        rsp_any_servable;
   logic        rsp_run_end;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [63:0] csr_pwdata = 64'd0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   http_byte_range_parser_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser shadow state
   parse_state_type ph;
   logic [2:0]   pfx_pos;
   logic [63:0]  first_val;
   logic [63:0]  second_val;
   logic         seen_serv;
   logic         syn_ok;
   logic [63:0]  file_len;

   rsp_item_type owed_results[$];
   rsp_item_type want_item;
   logic [7:0]   header_text[$];

   int cycle_count = 0;
   int error_count = 0;
   int sent_items = 0;
   int headers_sent = 0;
   int lengths_tried = 0;
   int intervals_checked = 0;
   int verdicts_checked = 0;
   int gap_max = 10;
   int stall_max = 10;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= 50) $display("ERROR [cycle %0d] %s", cycle_count, what);
   endtask

   function automatic void add_char(logic [7:0] c);
      header_text.insert(header_text.size(), c);
   endfunction

   // ---------------------------------------------------------------- range prediction

   function automatic logic is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic void clear_run();
      ph = ST_PREFIX;
      pfx_pos = 3'd0;
      first_val = 64'd0;
      second_val = 64'd0;
      seen_serv = 1'b0;
      syn_ok = 1'b1;
   endfunction

   function automatic void enter_error();
      ph = ST_ERROR;
      syn_ok = 1'b0;
   endfunction

   function automatic logic [63:0] add_digit(logic [63:0] v, logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - CH_ZERO);
      if (v > (ALL_ONES - d) / 64'd10) begin
         enter_error();
         return v;
      end
      return v * 64'd10 + d;
   endfunction

   function automatic void push_interval(logic [63:0] lo, logic [63:0] hi);
      rsp_item_type r;
      if (lo >= file_len) begin
         lo = file_len;
         hi = file_len;
      end else begin
         seen_serv = 1'b1;
      end
      r = '0;
      r.item_kind = KIND_RANGE;
      r.range_first = lo;
      r.range_limit = hi;
      owed_results.insert(owed_results.size(), r);
   endfunction

   function automatic void push_verdict(logic ok, logic serv);
      rsp_item_type r;
      r = '0;
      r.item_kind = KIND_VERDICT;
      r.header_ok = ok;
      r.any_servable = serv;
      r.run_end = 1'b1;
      owed_results.insert(owed_results.size(), r);
   endfunction

   function automatic logic close_suffix();
      if (first_val == 64'd0) begin
         enter_error();
         return 1'b0;
      end
      push_interval(first_val >= file_len ? 64'd0 : file_len - first_val, file_len);
      ph = ST_SPEC_DONE;
      return 1'b1;
   endfunction

   function automatic logic close_closed();
      logic [63:0] lim;
      if (second_val < first_val) begin
         enter_error();
         return 1'b0;
      end
      lim = (file_len == 64'd0 || second_val >= file_len - 64'd1) ? file_len
                                                                  : second_val + 64'd1;
      push_interval(first_val, lim);
      ph = ST_SPEC_DONE;
      return 1'b1;
   endfunction

   function automatic void close_open();
      push_interval(first_val, file_len);
      ph = ST_SPEC_DONE;
   endfunction

   function automatic void after_spec(logic [7:0] c);
      if (is_blank(c)) return;
      if (c == CH_COMMA) ph = ST_LEAD;
      else enter_error();
   endfunction

   function automatic void take_char(logic [7:0] c);
      logic [7:0] lc;
      case (ph)
         ST_PREFIX: begin
            lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
            if (lc == PREFIX_TEXT[8*(5-pfx_pos) +: 8]) begin
               pfx_pos++;
               if (pfx_pos == 3'd6) ph = ST_LEAD;
            end else begin
               ph = ST_BAD_PREFIX;
               syn_ok = 1'b0;
            end
         end
         ST_LEAD: begin
            if (is_blank(c)) ;
            else if (c == CH_DASH) ph = ST_SUFFIX_FIRST;
            else if (is_digit(c)) begin
               first_val = 64'(c - CH_ZERO);
               ph = ST_FIRST_NUM;
            end else enter_error();
         end
         ST_SUFFIX_FIRST: begin
            if (is_digit(c)) begin
               first_val = 64'(c - CH_ZERO);
               ph = ST_SUFFIX_DIGITS;
            end else enter_error();
         end
         ST_SUFFIX_DIGITS: begin
            if (is_digit(c)) first_val = add_digit(first_val, c);
            else if (close_suffix()) after_spec(c);
         end
         ST_FIRST_NUM: begin
            if (is_digit(c)) first_val = add_digit(first_val, c);
            else if (c == CH_DASH) ph = ST_DASH;
            else enter_error();
         end
         ST_DASH: begin
            if (c == CH_COMMA || is_blank(c)) begin
               close_open();
               after_spec(c);
            end else if (is_digit(c)) begin
               second_val = 64'(c - CH_ZERO);
               ph = ST_LAST_NUM;
            end else enter_error();
         end
         ST_LAST_NUM: begin
            if (is_digit(c)) second_val = add_digit(second_val, c);
            else if (close_closed()) after_spec(c);
         end
         ST_SPEC_DONE: after_spec(c);
         default: ;
      endcase
   endfunction

   function automatic void take_end();
      case (ph)
         ST_PREFIX: begin
            ph = ST_BAD_PREFIX;
            syn_ok = 1'b0;
         end
         ST_LEAD, ST_SUFFIX_FIRST, ST_FIRST_NUM: enter_error();
         ST_SUFFIX_DIGITS: void'(close_suffix());
         ST_DASH: close_open();
         ST_LAST_NUM: void'(close_closed());
         default: ;
      endcase
      if (ph == ST_BAD_PREFIX) push_verdict(1'b0, 1'b1);
      else push_verdict(syn_ok, seen_serv);
      clear_run();
   endfunction

   function automatic void predict_ranges(logic [7:0] c, logic fin, logic none);
      if (!none) take_char(c);
      if (fin) take_end();
   endfunction

   // ---------------------------------------------------------------- result checking

   always begin : rsp_pacing
      int stall;
      stall = $urandom_range(stall_max, 0);
      repeat (stall) @(negedge clock) rsp_ready <= 1'b0;
      @(negedge clock) rsp_ready <= 1'b1;
      do @(posedge clock); while (!rsp_valid);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want_item = owed_results.pop_front();
            if (want_item.item_kind == KIND_RANGE) intervals_checked++;
            else verdicts_checked++;
            if (rsp_item_kind !== want_item.item_kind)
               report_mismatch($sformatf("item_kind %b, expected %b",
                                         rsp_item_kind, want_item.item_kind));
            if (rsp_range_first !== want_item.range_first)
               report_mismatch($sformatf("range_first %0d, expected %0d",
                                         rsp_range_first, want_item.range_first));
            if (rsp_range_limit !== want_item.range_limit)
               report_mismatch($sformatf("range_limit %0d, expected %0d",
                                         rsp_range_limit, want_item.range_limit));
            if (rsp_header_ok !== want_item.header_ok)
               report_mismatch($sformatf("header_ok %b, expected %b",
                                         rsp_header_ok, want_item.header_ok));
            if (rsp_any_servable !== want_item.any_servable)
               report_mismatch($sformatf("any_servable %b, expected %b",
                                         rsp_any_servable, want_item.any_servable));
            if (rsp_run_end !== want_item.run_end)
               report_mismatch($sformatf("run_end %b, expected %b",
                                         rsp_run_end, want_item.run_end));
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_item(logic [7:0] ch, logic fin, logic none);
      int gap;
      gap = $urandom_range(gap_max, 0);
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_header_byte <= ch;
      req_is_final <= fin;
      req_no_byte <= none;
      do @(posedge clock); while (!req_ready);
      predict_ranges(ch, fin, none);
      if (!none || fin) sent_items++;
   endtask

   task automatic csr_write_length(logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= REG_FILE_LENGTH;
      csr_pwdata <= value;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      file_len = value;
      lengths_tried++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value)
         report_mismatch($sformatf("file_length reads %0d, expected %0d", csr_prdata, value));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // hold off input until every owed result has come back, then let the block settle
   task automatic set_file_length(logic [63:0] value);
      @(negedge clock) req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_length(value);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, 1'b0);
      headers_sent++;
   endtask

   task automatic send_header();
      int n;
      logic end_empty;
      n = header_text.size();
      end_empty = (n == 0) || ($urandom_range(9, 0) == 0);
      foreach (header_text[i]) begin
         if ($urandom_range(29, 0) == 0) send_item(8'($urandom), 1'b0, 1'b1);
         send_item(header_text[i], !end_empty && i == n - 1, 1'b0);
      end
      if (end_empty) send_item(8'($urandom), 1'b1, 1'b1);
      headers_sent++;
   endtask

   // ---------------------------------------------------------------- header generation

   function automatic logic [63:0] pick_offset();
      case ($urandom_range(5, 0))
         0: return 64'($urandom_range(20, 0));
         1: return file_len + 64'($urandom_range(4, 0)) - 64'd2;
         2: return {$urandom, $urandom};
         3: return 64'($urandom_range(1000, 0));
         4: return ALL_ONES - 64'($urandom_range(3, 0));
         default: return file_len >> $urandom_range(4, 1);
      endcase
   endfunction

   function automatic void append_blanks();
      if ($urandom_range(2, 0) == 0)
         repeat ($urandom_range(2, 1))
            add_char($urandom_range(1, 0) ? CH_SPACE : CH_TAB);
   endfunction

   function automatic void append_decimal(logic [63:0] v);
      logic [7:0] digits[$];
      int zeros;
      zeros = ($urandom_range(7, 0) == 0) ? $urandom_range(3, 1) : 0;
      do begin
         digits.push_front(CH_ZERO + 8'(v % 64'd10));
         v = v / 64'd10;
      end while (v != 64'd0);
      repeat (zeros) add_char(CH_ZERO);
      foreach (digits[i]) add_char(digits[i]);
   endfunction

   function automatic void append_spec(spec_kind_type kind);
      logic [63:0] a;
      logic [63:0] b;
      case (kind)
         SPEC_CLOSED: begin
            a = pick_offset();
            b = pick_offset();
            if (b < a) begin
               a = a ^ b;
               b = a ^ b;
               a = a ^ b;
            end
            append_decimal(a);
            add_char(CH_DASH);
            append_decimal(b);
         end
         SPEC_OPEN: begin
            append_decimal(pick_offset());
            add_char(CH_DASH);
         end
         SPEC_SUFFIX: begin
            a = pick_offset();
            if (a == 64'd0) a = 64'd1;
            add_char(CH_DASH);
            append_decimal(a);
         end
         SPEC_BACKWARD: begin
            a = pick_offset();
            if (a == 64'd0) a = 64'd1;
            b = {$urandom, $urandom} % a;
            append_decimal(a);
            add_char(CH_DASH);
            append_decimal(b);
         end
         SPEC_ZERO_SUFFIX: begin
            add_char(CH_DASH);
            append_decimal(64'd0);
         end
         SPEC_BARE_DASH: add_char(CH_DASH);
         SPEC_OVERFLOW: begin
            // one digit past the largest prefix of the offset limit: 6 to 9 overflow
            if ($urandom_range(1, 0)) begin
               add_char(CH_ZERO);
               add_char(CH_DASH);
               append_decimal(ALL_ONES / 64'd10);
               add_char(CH_ZERO + 8'($urandom_range(9, 0)));
            end else begin
               append_decimal(ALL_ONES / 64'd10);
               add_char(CH_ZERO + 8'($urandom_range(9, 0)));
               add_char(CH_DASH);
            end
         end
         default: add_char(8'($urandom));
      endcase
   endfunction

   function automatic void build_header(int defect_pct);
      int cut;
      int specs;
      logic truncate;
      logic [7:0] ch;
      spec_kind_type kind;
      header_text.delete();
      cut = 6;
      truncate = $urandom_range(1, 0);
      if ($urandom_range(99, 0) < defect_pct && $urandom_range(3, 0) == 0)
         cut = $urandom_range(5, 0);
      for (int p = 0; p < 6; p++) begin
         if (p == cut && truncate) return;
         ch = PREFIX_TEXT[8*(5-p) +: 8];
         if (p == cut) ch = 8'($urandom);
         else if (ch != CH_EQUALS && $urandom_range(1, 0)) ch = ch - CASE_GAP;
         add_char(ch);
      end
      specs = $urandom_range(4, 1);
      if (defect_pct > 0 && $urandom_range(19, 0) == 0) specs = 0;
      for (int s = 0; s < specs; s++) begin
         if (s > 0) begin
            append_blanks();
            add_char(CH_COMMA);
         end
         append_blanks();
         if ($urandom_range(99, 0) >= defect_pct)
            kind = spec_kind_type'($urandom_range(SPEC_SUFFIX, SPEC_CLOSED));
         else if ($urandom_range(1, 0))
            kind = SPEC_OVERFLOW;
         else
            kind = spec_kind_type'($urandom_range(SPEC_STRAY, SPEC_BACKWARD));
         append_spec(kind);
      end
      append_blanks();
      if (defect_pct > 0 && $urandom_range(19, 0) == 0) add_char(CH_COMMA);
   endfunction

   function automatic void build_noise_header();
      header_text.delete();
      if ($urandom_range(1, 0))
         for (int p = 0; p < 6; p++) add_char(PREFIX_TEXT[8*(5-p) +: 8]);
      repeat ($urandom_range(10, 1)) begin
         case ($urandom_range(5, 0))
            0: add_char(CH_DASH);
            1: add_char(CH_COMMA);
            2: add_char($urandom_range(1, 0) ? CH_SPACE : CH_TAB);
            3: add_char(CH_ZERO + 8'($urandom_range(9, 0)));
            default: add_char(8'($urandom));
         endcase
      end
   endfunction

   task automatic run_headers(int n_items, int defect_pct, int noise_pct);
      int target;
      target = sent_items + n_items;
      while (sent_items < target) begin
         gap_max = ($urandom_range(3, 0) == 0) ? 0 : 10;
         stall_max = ($urandom_range(3, 0) == 0) ? 0 : 10;
         if ($urandom_range(99, 0) < noise_pct) build_noise_header();
         else build_header(defect_pct);
         send_header();
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      set_file_length(64'd100);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_text("bYtEs=2-,\t-7");
      send_text("BYTES=9-3");
   endtask

   task automatic test_well_formed_headers();
      set_file_length(64'd1000);
      run_headers(230, 0, 0);
      set_file_length(64'd1);
      run_headers(230, 0, 0);
      set_file_length({32'd1, $urandom});
      run_headers(230, 0, 0);
   endtask

   task automatic test_malformed_headers();
      set_file_length(64'd50);
      run_headers(200, 30, 15);
      set_file_length(64'($urandom));
      run_headers(200, 30, 15);
   endtask

   task automatic test_offset_extremes();
      set_file_length(64'd0);
      run_headers(110, 25, 5);
      set_file_length(ALL_ONES);
      run_headers(110, 25, 5);
      set_file_length(64'h8000_0000_0000_0000);
      run_headers(110, 25, 5);
      set_file_length(ALL_ONES - 64'd1);
      run_headers(110, 25, 5);
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      clear_run();
      file_len = 64'd0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_directed_cases();
      test_well_formed_headers();
      test_malformed_headers();
      test_offset_extremes();

      @(negedge clock) req_valid <= 1'b0;
      repeat (2000) begin
         if (owed_results.size() == 0) break;
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (owed_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", owed_results.size()));

      $display("summary: %0d headers in %0d input transfers over %0d file lengths",
               headers_sent, sent_items, lengths_tried);
      $display("summary: %0d intervals and %0d verdicts checked, %0d mismatches",
               intervals_checked, verdicts_checked, error_count);
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
